/* rtl/core/itcf_pkg.sv */
// Shared constants, types and arithmetic helpers for the tilt filter.
package itcf_pkg;

    // Defaults for the top-level parameters
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 24;

    // Serial multiplier operand and product widths (signed)
    localparam int MUL_AW = 41;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Accumulator, CORDIC vector and CORDIC angle widths
    localparam int ACC_W = 76;
    localparam int CW    = 42;
    localparam int ZW    = 36;

    // Angles in Q6.30 radians
    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic [39:0]          TWO_PI_WIDE = 40'd6746518852;

    // CORDIC gain and filter weights, Q2.30
    localparam logic signed [MUL_BW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [MUL_BW-1:0] W_ACC    = 33'sd429497;
    localparam logic signed [MUL_BW-1:0] W_KEEP   = 33'sd1073312327;
    localparam logic signed [MUL_BW-1:0] W_NEW    = 33'sd107374182;
    localparam logic signed [MUL_BW-1:0] W_OLD    = 33'sd966367642;

    localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(32'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] MIN32 = ACC_W'(32'sh80000000);

    // Request and response between sequencer and multiplier
    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_PW-1:0] p;
    } t_mul_rsp;

    // arctan(2^-i) in Q2.30 radians
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Round half up, then arithmetic shift right
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] v,
        input int                      s
    );
        logic signed [ACC_W-1:0] b;
        b = ACC_W'(1) <<< (s - 1);
        return (v + b) >>> s;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFFFFFF;
        end else if (v < MIN32) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/imu_tilt_complementary_filter.sv */
// Top level: pitch and roll tilt estimator with complementary filter.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  sample   | i_valid / o_ready   | i_accel_x/y/z, i_rate_x/y/z (16b signed)
//  angles   | o_valid / i_ready   | o_pitch/roll_smoothed, o_pitch/roll_fused
//  config   | i_cfg_we            | i_cfg_idx (3b), i_cfg_data (32b)
//
// The time a sample takes is set by the bit-serial multiplier and the CORDIC,
// one rotation per cycle; a zero acceleration vector skips the tilt vectoring
// and the first sample after reset skips the blend. Reset is synchronous and
// active low; it clears the angles and loads the register defaults. A result
// that is not taken holds in the output register; the next sample is accepted
// meanwhile and waits at its last step until that transfer is done.
module imu_tilt_complementary_filter #(
    parameter int ANGLE_FRAC_BITS = itcf_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = itcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pitch_smoothed,
    output logic signed [31:0] o_roll_smoothed,
    output logic signed [31:0] o_pitch_fused,
    output logic signed [31:0] o_roll_fused,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int ACC_W   = itcf_pkg::ACC_W;
    localparam int CW      = itcf_pkg::CW;
    localparam int ZW      = itcf_pkg::ZW;
    localparam int AW      = itcf_pkg::MUL_AW;
    localparam int BW      = itcf_pkg::MUL_BW;
    localparam int IT_W    = $clog2(CORDIC_STEPS);
    localparam int SH_RATE = 32 - ANGLE_FRAC_BITS;
    localparam int SH_YAW  = 10;
    localparam int SH_Q30  = 30;
    localparam int SH_DEG  = 46 - ANGLE_FRAC_BITS;

    localparam logic [2:0] CFG_GX_OFF = 3'd0;
    localparam logic [2:0] CFG_GY_OFF = 3'd1;
    localparam logic [2:0] CFG_GZ_OFF = 3'd2;
    localparam logic [2:0] CFG_R2DEG  = 3'd3;
    localparam logic [2:0] CFG_R2RAD  = 3'd4;
    localparam logic [2:0] CFG_RAD2D  = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GX, ST_GY, ST_GZ, ST_RED, ST_SIN, ST_CP, ST_CR,
        ST_V1P, ST_HP, ST_V2P, ST_RP, ST_V1R, ST_HR, ST_V2R, ST_RR,
        ST_MIX, ST_BP1, ST_BP2, ST_BR1, ST_BR2, ST_DP1, ST_DP2, ST_DR1, ST_DR2,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_run;
    logic [IT_W-1:0]         r_it;
    logic                    r_ovalid;
    logic                    r_started;

    logic signed [15:0]      r_gx_off, r_gy_off, r_gz_off;
    logic [31:0]             r_rtd, r_rtr;
    logic [23:0]             r_r2d;

    logic signed [31:0]      r_pitch, r_roll, r_pd, r_rd, r_pacc, r_racc;
    logic signed [15:0]      r_ax, r_ay, r_az;
    logic signed [16:0]      r_gx, r_gy, r_gz;
    logic signed [ACC_W-1:0] r_acc;
    logic [38:0]             r_zm;
    logic                    r_zneg;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ZW-1:0]    r_cz;
    logic signed [AW-1:0]    r_h;
    logic signed [31:0]      r_o_ps, r_o_rs, r_o_pf, r_o_rf;

    itcf_pkg::t_mul_req      w_req;
    itcf_pkg::t_mul_rsp      w_rsp;

    logic signed [ACC_W-1:0] w_sum, w_rs_rate, w_rs_yaw, w_rs_q30, w_rs_deg;
    logic [ACC_W-1:0]        w_zabs;
    logic [39:0]             w_tp, w_zdiff;
    logic [38:0]             n_zm;
    logic signed [ZW-1:0]    w_zpos, w_zr;
    logic                    w_is_mul;
    logic                    w_rot, w_up, w_zero;
    logic signed [CW-1:0]    w_dx, w_dy, n_cx, n_cy;
    logic signed [ZW-1:0]    w_at, n_cz;
    logic signed [CW-1:0]    w_ld_cx, w_ld_cy;
    logic signed [ZW-1:0]    w_ld_cz;
    t_state                  w_cord_next;
    logic signed [16:0]      w_ax17, w_ay17, w_abs_ax, w_abs_ay;

    // Fold a reduced angle into [-pi/2, pi/2] keeping its sine
    function automatic logic signed [ZW-1:0] fold_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] v;
        v = z;
        if (v > itcf_pkg::PI_Q30) begin
            v = v - itcf_pkg::TWO_PI_Q30;
        end
        if (v < -itcf_pkg::PI_Q30) begin
            v = v + itcf_pkg::TWO_PI_Q30;
        end
        if (v > itcf_pkg::HALF_PI_Q30) begin
            v = itcf_pkg::PI_Q30 - v;
        end
        if (v < -itcf_pkg::HALF_PI_Q30) begin
            v = -itcf_pkg::PI_Q30 - v;
        end
        return v;
    endfunction

    itcf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Product results, rounded at each scale in use
    assign w_sum     = r_acc + ACC_W'(w_rsp.p);
    assign w_rs_rate = itcf_pkg::round_shift(w_sum, SH_RATE);
    assign w_rs_yaw  = itcf_pkg::round_shift(w_sum, SH_YAW);
    assign w_rs_q30  = itcf_pkg::round_shift(w_sum, SH_Q30);
    assign w_rs_deg  = itcf_pkg::round_shift(w_sum, SH_DEG);
    assign w_zabs    = w_rs_yaw[ACC_W-1] ? ACC_W'(-w_rs_yaw) : ACC_W'(w_rs_yaw);

    // Yaw angle reduction: one trial subtraction of 2*pi*2^k per cycle
    assign w_tp   = itcf_pkg::TWO_PI_WIDE << r_it;
    assign w_zdiff = {1'b0, r_zm} - w_tp;
    assign n_zm   = ({1'b0, r_zm} >= w_tp) ? w_zdiff[38:0] : r_zm;
    assign w_zpos = signed'(ZW'(n_zm));
    assign w_zr   = r_zneg ? -w_zpos : w_zpos;

    // One CORDIC micro-rotation, rotation mode for sin, vectoring otherwise
    assign w_rot = (r_state == ST_SIN);
    assign w_dx  = r_cy >>> r_it;
    assign w_dy  = r_cx >>> r_it;
    assign w_at  = signed'(ZW'(itcf_pkg::atan_q30(5'(r_it))));
    assign w_up  = w_rot ? ~r_cz[ZW-1] : r_cy[CW-1];
    assign n_cx  = w_up ? r_cx - w_dx : r_cx + w_dx;
    assign n_cy  = w_up ? r_cy + w_dy : r_cy - w_dy;
    assign n_cz  = w_up ? r_cz - w_at : r_cz + w_at;

    // Tilt vectors
    assign w_ax17   = 17'(r_ax);
    assign w_ay17   = 17'(r_ay);
    assign w_abs_ax = w_ax17[16] ? -w_ax17 : w_ax17;
    assign w_abs_ay = w_ay17[16] ? -w_ay17 : w_ay17;
    assign w_zero   = (r_ax == 16'sd0) && (r_ay == 16'sd0) && (r_az == 16'sd0);

    // CORDIC start values and the step that follows each pass
    always_comb begin
        w_ld_cx     = '0;
        w_ld_cy     = '0;
        w_ld_cz     = '0;
        w_cord_next = ST_CP;
        case (r_state)
            ST_SIN: begin
                w_ld_cx     = CW'(itcf_pkg::GAIN_Q30);
                w_ld_cz     = r_cz;
                w_cord_next = ST_CP;
            end
            ST_V1P: begin
                w_ld_cx     = CW'(w_abs_ax) <<< 16;
                w_ld_cy     = CW'(r_az) <<< 16;
                w_cord_next = ST_HP;
            end
            ST_V2P: begin
                w_ld_cx     = CW'(r_h);
                w_ld_cy     = CW'(r_ay) <<< 16;
                w_cord_next = ST_RP;
            end
            ST_V1R: begin
                w_ld_cx     = CW'(w_abs_ay) <<< 16;
                w_ld_cy     = CW'(r_az) <<< 16;
                w_cord_next = ST_HR;
            end
            ST_V2R: begin
                w_ld_cx     = CW'(r_h);
                w_ld_cy     = CW'(r_ax) <<< 16;
                w_cord_next = ST_RR;
            end
            default: begin
                w_cord_next = ST_CP;
            end
        endcase
    end

    // Multiplier operands for each step
    always_comb begin
        w_is_mul = 1'b1;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state) inside
            ST_GX:          begin w_req.a = AW'(r_gx); w_req.b = BW'({1'b0, r_rtd}); end
            ST_GY:          begin w_req.a = AW'(r_gy); w_req.b = BW'({1'b0, r_rtd}); end
            ST_GZ:          begin w_req.a = AW'(r_gz); w_req.b = BW'({1'b0, r_rtr}); end
            ST_CP:          begin w_req.a = AW'(r_roll); w_req.b = r_cy[BW-1:0]; end
            ST_CR:          begin w_req.a = AW'(r_pitch); w_req.b = r_cy[BW-1:0]; end
            ST_HP, ST_HR:   begin w_req.a = r_cx[AW-1:0]; w_req.b = itcf_pkg::GAIN_Q30; end
            ST_RP, ST_RR:   begin w_req.a = AW'(r_cz); w_req.b = BW'({9'd0, r_r2d}); end
            ST_BP1:         begin w_req.a = AW'(r_pitch); w_req.b = itcf_pkg::W_KEEP; end
            ST_BP2:         begin w_req.a = AW'(r_pacc); w_req.b = itcf_pkg::W_ACC; end
            ST_BR1:         begin w_req.a = AW'(r_roll); w_req.b = itcf_pkg::W_KEEP; end
            ST_BR2:         begin w_req.a = AW'(r_racc); w_req.b = itcf_pkg::W_ACC; end
            ST_DP1:         begin w_req.a = AW'(r_pd); w_req.b = itcf_pkg::W_OLD; end
            ST_DP2:         begin w_req.a = AW'(r_pitch); w_req.b = itcf_pkg::W_NEW; end
            ST_DR1:         begin w_req.a = AW'(r_rd); w_req.b = itcf_pkg::W_OLD; end
            ST_DR2:         begin w_req.a = AW'(r_roll); w_req.b = itcf_pkg::W_NEW; end
            default:        w_is_mul = 1'b0;
        endcase
        w_req.start = w_is_mul && !r_run;
    end

    // Sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_run     <= 1'b0;
            r_it      <= '0;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
            r_acc     <= '0;
            r_pitch   <= '0;
            r_roll    <= '0;
            r_pd      <= '0;
            r_rd      <= '0;
            r_gx_off  <= '0;
            r_gy_off  <= '0;
            r_gz_off  <= '0;
            r_rtd     <= 32'd262424;
            r_rtr     <= 32'd1172078;
            r_r2d     <= 24'd3754936;
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GX_OFF: r_gx_off <= i_cfg_data[15:0];
                    CFG_GY_OFF: r_gy_off <= i_cfg_data[15:0];
                    CFG_GZ_OFF: r_gz_off <= i_cfg_data[15:0];
                    CFG_R2DEG:  r_rtd    <= i_cfg_data;
                    CFG_R2RAD:  r_rtr    <= i_cfg_data;
                    CFG_RAD2D:  r_r2d    <= i_cfg_data[23:0];
                    default:    ;
                endcase
            end

            // drop the result once transferred, unless a new one replaces it
            if (r_ovalid && i_ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_ax    <= i_accel_x;
                        r_ay    <= i_accel_y;
                        r_az    <= i_accel_z;
                        r_gx    <= 17'(i_rate_x) - 17'(r_gx_off);
                        r_gy    <= 17'(i_rate_y) - 17'(r_gy_off);
                        r_gz    <= 17'(i_rate_z) - 17'(r_gz_off);
                        r_run   <= 1'b0;
                        r_state <= ST_GX;
                    end
                end
                ST_GX, ST_GY, ST_GZ, ST_CP, ST_CR, ST_HP, ST_HR, ST_RP, ST_RR,
                ST_BP1, ST_BP2, ST_BR1, ST_BR2, ST_DP1, ST_DP2, ST_DR1, ST_DR2: begin
                    if (!r_run) begin
                        r_run <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_run <= 1'b0;
                        case (r_state)
                            ST_GX: begin
                                r_pitch <= itcf_pkg::sat32(ACC_W'(r_pitch) + w_rs_rate);
                                r_state <= ST_GY;
                            end
                            ST_GY: begin
                                r_roll  <= itcf_pkg::sat32(ACC_W'(r_roll) + w_rs_rate);
                                r_state <= ST_GZ;
                            end
                            ST_GZ: begin
                                r_zneg  <= w_rs_yaw[ACC_W-1];
                                r_zm    <= w_zabs[38:0];
                                r_it    <= IT_W'(6);
                                r_state <= ST_RED;
                            end
                            ST_CP: begin
                                r_pitch <= itcf_pkg::sat32(ACC_W'(r_pitch) + w_rs_q30);
                                r_state <= ST_CR;
                            end
                            ST_CR: begin
                                r_roll <= itcf_pkg::sat32(ACC_W'(r_roll) - w_rs_q30);
                                if (w_zero) begin
                                    r_pacc  <= '0;
                                    r_racc  <= '0;
                                    r_state <= ST_MIX;
                                end else begin
                                    r_state <= ST_V1P;
                                end
                            end
                            ST_HP: begin
                                r_h     <= w_rs_q30[AW-1:0];
                                r_state <= ST_V2P;
                            end
                            ST_HR: begin
                                r_h     <= w_rs_q30[AW-1:0];
                                r_state <= ST_V2R;
                            end
                            ST_RP: begin
                                r_pacc  <= itcf_pkg::sat32(w_rs_deg);
                                r_state <= ST_V1R;
                            end
                            ST_RR: begin
                                r_racc  <= itcf_pkg::sat32(-w_rs_deg);
                                r_state <= ST_MIX;
                            end
                            ST_BP1: begin
                                r_acc   <= w_sum;
                                r_state <= ST_BP2;
                            end
                            ST_BP2: begin
                                r_acc   <= '0;
                                r_pitch <= itcf_pkg::sat32(w_rs_q30);
                                r_state <= ST_BR1;
                            end
                            ST_BR1: begin
                                r_acc   <= w_sum;
                                r_state <= ST_BR2;
                            end
                            ST_BR2: begin
                                r_acc   <= '0;
                                r_roll  <= itcf_pkg::sat32(w_rs_q30);
                                r_state <= ST_DP1;
                            end
                            ST_DP1: begin
                                r_acc   <= w_sum;
                                r_state <= ST_DP2;
                            end
                            ST_DP2: begin
                                r_acc   <= '0;
                                r_pd    <= itcf_pkg::sat32(w_rs_q30);
                                r_state <= ST_DR1;
                            end
                            ST_DR1: begin
                                r_acc   <= w_sum;
                                r_state <= ST_DR2;
                            end
                            default: begin
                                r_acc   <= '0;
                                r_rd    <= itcf_pkg::sat32(w_rs_q30);
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RED: begin
                    r_zm <= n_zm;
                    if (r_it == '0) begin
                        r_cz    <= fold_angle(w_zr);
                        r_run   <= 1'b0;
                        r_state <= ST_SIN;
                    end else begin
                        r_it <= r_it - 1'b1;
                    end
                end
                ST_SIN, ST_V1P, ST_V2P, ST_V1R, ST_V2R: begin
                    if (!r_run) begin
                        r_cx  <= w_ld_cx;
                        r_cy  <= w_ld_cy;
                        r_cz  <= w_ld_cz;
                        r_it  <= '0;
                        r_run <= 1'b1;
                    end else begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_cz <= n_cz;
                        if (r_it == IT_W'(CORDIC_STEPS - 1)) begin
                            r_run   <= 1'b0;
                            r_state <= w_cord_next;
                        end else begin
                            r_it <= r_it + 1'b1;
                        end
                    end
                end
                ST_MIX: begin
                    // first sample loads the tilt outright
                    r_run <= 1'b0;
                    if (r_started) begin
                        r_state <= ST_BP1;
                    end else begin
                        r_pitch   <= r_pacc;
                        r_roll    <= r_racc;
                        r_started <= 1'b1;
                        r_state   <= ST_DP1;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_o_ps   <= r_pd;
                        r_o_rs   <= r_rd;
                        r_o_pf   <= r_pitch;
                        r_o_rf   <= r_roll;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_pitch_smoothed = r_o_ps;
    assign o_roll_smoothed  = r_o_rs;
    assign o_pitch_fused    = r_o_pf;
    assign o_roll_fused     = r_o_rf;

endmodule

/* rtl/core/itcf_mul.sv */
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module itcf_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itcf_pkg::t_mul_req i_req,
    output itcf_pkg::t_mul_rsp o_rsp
);

    localparam int AW    = itcf_pkg::MUL_AW;
    localparam int BW    = itcf_pkg::MUL_BW;
    localparam int PW    = itcf_pkg::MUL_PW;
    localparam int CNT_W = $clog2(BW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_am;
    logic [AW-1:0]    r_hi;
    logic [BW-1:0]    r_lo;
    logic             r_neg;

    logic [AW-1:0]    w_am;
    logic [BW-1:0]    w_bm;
    logic [AW:0]      w_sum;
    logic [PW-1:0]    w_prod;

    // Operand magnitudes; the sign is applied at the end
    assign w_am = i_req.a[AW-1] ? AW'(-i_req.a) : AW'(i_req.a);
    assign w_bm = i_req.b[BW-1] ? BW'(-i_req.b) : BW'(i_req.b);

    // Add the multiplicand when the current multiplier bit is set
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_am} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                // advance one bit: shift the partial product right
                r_hi <= w_sum[AW:1];
                r_lo <= {w_sum[0], r_lo[BW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_am   <= w_am;
                r_hi   <= '0;
                r_lo   <= w_bm;
                r_neg  <= i_req.a[AW-1] ^ i_req.b[BW-1];
            end
        end
    end

    // Signed product, valid while done is high
    assign w_prod     = {r_hi, r_lo};
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_neg ? -signed'(w_prod) : signed'(w_prod);

endmodule

/* rtl/core/itcf_checker.sv */
// Port-level checks for the tilt filter, bound to the top level.
module itcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_pitch_smoothed,
    input logic [31:0] o_roll_smoothed,
    input logic [31:0] o_pitch_fused,
    input logic [31:0] o_roll_fused
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pitch_smoothed) &&
        $stable(o_roll_smoothed) && $stable(o_pitch_fused) && $stable(o_roll_fused))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The block is busy right after a sample transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a transfer");

    // A newly raised result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result raised while busy");

endmodule

bind imu_tilt_complementary_filter itcf_checker u_itcf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_pitch_smoothed (o_pitch_smoothed),
    .o_roll_smoothed  (o_roll_smoothed),
    .o_pitch_fused    (o_pitch_fused),
    .o_roll_fused     (o_roll_fused)
);

/* tb/testbench.sv */
// Self-checking testbench for the IMU tilt complementary filter.
`timescale 1ns / 1ps

module testbench;

    localparam int  FRAC_BITS   = 16;
    localparam int  ROT_STEPS   = 24;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  LONG_HOLD   = 3000;

    localparam longint PI_RAD      = 64'sd3373259426;
    localparam longint HALF_PI_RAD = 64'sd1686629713;
    localparam longint TWO_PI_RAD  = 64'sd6746518852;
    localparam longint GAIN        = 64'sd652032874;
    localparam longint KEEP_W      = 64'sd1073312327;
    localparam longint TILT_W      = 64'sd429497;
    localparam longint OLD_W       = 64'sd966367642;
    localparam longint NEW_W       = 64'sd107374182;

    typedef enum logic [2:0] {
        REG_GYRO_X   = 3'd0,
        REG_GYRO_Y   = 3'd1,
        REG_GYRO_Z   = 3'd2,
        REG_RATE_DEG = 3'd3,
        REG_RATE_RAD = 3'd4,
        REG_RAD_DEG  = 3'd5,
        REG_SPARE    = 3'd7
    } reg_idx_t;

    typedef struct {
        logic signed [15:0] ax, ay, az, rx, ry, rz;
    } sample_t;

    typedef struct {
        logic signed [31:0] ps, rs, pf, rf;
    } angles_t;

    typedef struct {
        sample_t s;
        bit      known;
        angles_t a;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [15:0] i_rate_x = '0, i_rate_y = '0, i_rate_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_pitch_smoothed, o_roll_smoothed, o_pitch_fused, o_roll_fused;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    imu_tilt_complementary_filter i_dut (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of configuration and state
    longint off_x, off_y, off_z, deg_per_lsb, rad_per_lsb, deg_per_rad;
    longint pitch_st, roll_st, pitch_dmp, roll_dmp;
    bit     started;

    angles_t expected_angles[$];
    int      mismatches = 0;
    longint  cycles = 0;
    bit      burst = 0;
    bit      hold_request = 0;

    function automatic longint rshift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint tab[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tab[i];
    endfunction

    // Rotation-mode sine with range folding
    function automatic longint yaw_sine(longint z);
        longint x, y, dx, dy;
        x = GAIN;
        y = 0;
        z = z % TWO_PI_RAD;
        if (z > PI_RAD) z -= TWO_PI_RAD;
        if (z < -PI_RAD) z += TWO_PI_RAD;
        if (z > HALF_PI_RAD) z = PI_RAD - z;
        if (z < -HALF_PI_RAD) z = -PI_RAD - z;
        for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        return y;
    endfunction

    // Vectoring mode: magnitude returned, angle through ang
    function automatic longint vector_mag(longint x, longint y, output longint ang);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        ang = z;
        return x;
    endfunction

    function automatic longint tilt_deg(longint a, longint b, longint c);
        longint ang, h;
        if (b < 0) b = -b;
        h = vector_mag(b * 65536, c * 65536, ang);
        h = rshift(h * GAIN, 30);
        h = vector_mag(h, a * 65536, ang);
        return rshift(ang * deg_per_rad, 46 - FRAC_BITS);
    endfunction

    function automatic angles_t predict_angles(sample_t s);
        angles_t r;
        longint gx, gy, gz, sn, pacc, racc;
        gx = longint'(s.rx) - off_x;
        gy = longint'(s.ry) - off_y;
        gz = longint'(s.rz) - off_z;
        pitch_st = clamp32(pitch_st + rshift(gx * deg_per_lsb, 32 - FRAC_BITS));
        roll_st  = clamp32(roll_st + rshift(gy * deg_per_lsb, 32 - FRAC_BITS));
        sn = yaw_sine(rshift(gz * rad_per_lsb, 10));
        pitch_st = clamp32(pitch_st + rshift(roll_st * sn, 30));
        roll_st  = clamp32(roll_st - rshift(pitch_st * sn, 30));
        if (s.ax == 0 && s.ay == 0 && s.az == 0) begin
            pacc = 0;
            racc = 0;
        end else begin
            pacc = clamp32(tilt_deg(s.ay, s.ax, s.az));
            racc = clamp32(-tilt_deg(s.ax, s.ay, s.az));
        end
        if (started) begin
            pitch_st = clamp32(rshift(pitch_st * KEEP_W + pacc * TILT_W, 30));
            roll_st  = clamp32(rshift(roll_st * KEEP_W + racc * TILT_W, 30));
        end else begin
            pitch_st = pacc;
            roll_st  = racc;
            started  = 1;
        end
        pitch_dmp = clamp32(rshift(pitch_dmp * OLD_W + pitch_st * NEW_W, 30));
        roll_dmp  = clamp32(rshift(roll_dmp * OLD_W + roll_st * NEW_W, 30));
        r.ps = pitch_dmp[31:0];
        r.rs = roll_dmp[31:0];
        r.pf = pitch_st[31:0];
        r.rf = roll_st[31:0];
        return r;
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_GYRO_X:   off_x = longint'($signed(data[15:0]));
            REG_GYRO_Y:   off_y = longint'($signed(data[15:0]));
            REG_GYRO_Z:   off_z = longint'($signed(data[15:0]));
            REG_RATE_DEG: deg_per_lsb = longint'(data);
            REG_RATE_RAD: rad_per_lsb = longint'(data);
            REG_RAD_DEG:  deg_per_rad = longint'(data[23:0]);
            default: ;
        endcase
    endtask

    // Offer one sample, hold it until transfer, then queue its expected angles
    task automatic send_sample(sample_t s, bit known, angles_t a);
        int gap;
        angles_t p;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= s.ax;
        i_accel_y <= s.ay;
        i_accel_z <= s.az;
        i_rate_x  <= s.rx;
        i_rate_y  <= s.ry;
        i_rate_z  <= s.rz;
        do @(posedge i_clk); while (!o_ready);
        p = predict_angles(s);
        expected_angles.push_back(known ? a : p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 11))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3, 4: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random ready gaps, one long hold-off on request
    initial begin
        int gap;
        forever begin
            gap = burst ? 0 : $urandom_range(0, 14);
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        angles_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = expected_angles.pop_front();
                if (o_pitch_smoothed !== e.ps || o_roll_smoothed !== e.rs ||
                    o_pitch_fused !== e.pf || o_roll_fused !== e.rf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.ps, e.rs, e.pf, e.rf, o_pitch_smoothed,
                                 o_roll_smoothed, o_pitch_fused, o_roll_fused);
                end
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence
    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        sample_t   s;
        angles_t   zero_a;
        zero_a = '{0, 0, 0, 0};
        off_x = 0; off_y = 0; off_z = 0;
        deg_per_lsb = 262424; rad_per_lsb = 1172078; deg_per_rad = 3754936;
        pitch_st = 0; roll_st = 0; pitch_dmp = 0; roll_dmp = 0; started = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; only the first one after reset is read off by hand
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, zero_a});
        rows.push_back('{'{0, 0, 16384, 0, 0, 0}, 0, zero_a});
        rows.push_back('{'{16384, 0, 0, 0, 0, 0}, 0, zero_a});
        rows.push_back('{'{0, -16384, 0, 0, 0, 0}, 0, zero_a});
        rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767}, 0, zero_a});
        rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768}, 0, zero_a});
        rows.push_back('{'{0, 0, 0, 1000, -1000, 500}, 0, zero_a});
        rows.push_back('{'{-32768, 0, 0, 0, 0, 32767}, 0, zero_a});
        rows.push_back('{'{0, 32767, -32768, -32768, 32767, 0}, 0, zero_a});
        rows.push_back('{'{1, -1, 1, -1, 1, -1}, 0, zero_a});
        rows.push_back('{'{-1, 0, 0, 0, 0, 0}, 0, zero_a});
        rows.push_back('{'{300, -200, 16000, 12, -7, 3}, 0, zero_a});
        foreach (rows[i]) send_sample(rows[i].s, rows[i].known, rows[i].a);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_GYRO_X, 32'h0000_8000);
                    write_reg(REG_GYRO_Y, 32'h0000_7FFF);
                    write_reg(REG_GYRO_Z, 32'hFFFF_0000);
                    write_reg(REG_RATE_DEG, 32'hFFFF_FFFF);
                    write_reg(REG_RATE_RAD, 32'hFFFF_FFFF);
                    write_reg(REG_RAD_DEG, 32'h00FF_FFFF);
                    write_reg(REG_SPARE, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(REG_GYRO_X, 32'h0000_7FFF);
                    write_reg(REG_GYRO_Y, 32'h0000_8000);
                    write_reg(REG_GYRO_Z, 32'h0000_7FFF);
                    write_reg(REG_RATE_DEG, 32'h0);
                    write_reg(REG_RATE_RAD, 32'h0);
                    write_reg(REG_RAD_DEG, 32'h0);
                end
                2: begin
                    write_reg(REG_GYRO_X, 32'd0);
                    write_reg(REG_GYRO_Y, 32'd0);
                    write_reg(REG_GYRO_Z, 32'd0);
                    write_reg(REG_RATE_DEG, 32'd262424);
                    write_reg(REG_RATE_RAD, 32'd1172078);
                    write_reg(REG_RAD_DEG, 32'd3754936);
                end
                default: begin
                    write_reg(REG_GYRO_X, $urandom);
                    write_reg(REG_GYRO_Y, $urandom);
                    write_reg(REG_GYRO_Z, $urandom);
                    write_reg(REG_RATE_DEG, ph == 5 ? $urandom : $urandom_range(0, 1 << 20));
                    write_reg(REG_RATE_RAD, ph == 5 ? $urandom : $urandom_range(0, 1 << 24));
                    write_reg(REG_RAD_DEG, $urandom);
                end
            endcase
            burst = (ph == 3);
            for (int n = 0; n < 75; n++) begin
                // Long receiver hold-off while samples keep coming
                if (ph == 2 && n == 10) hold_request = 1;
                s.ax = rand_field(); s.ay = rand_field(); s.az = rand_field();
                s.rx = rand_field(); s.ry = rand_field(); s.rz = rand_field();
                if ($urandom_range(0, 15) == 0) begin
                    s.ax = 0; s.ay = 0; s.az = 0;
                end
                send_sample(s, 0, zero_a);
            end
            drain();
            burst = 0;
        end

        repeat (1000) @(posedge i_clk);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/itcf_pkg.sv
rtl/core/itcf_mul.sv
rtl/core/imu_tilt_complementary_filter.sv
rtl/core/itcf_checker.sv
tb/testbench.sv
